// ===== rtl/swsp_pkg.sv =====
package swsp_pkg;

    localparam int REQ_W            = 3;
    localparam int ID_W             = 4;
    localparam int MS_W             = 32;
    localparam int ID_SPACE         = 16;
    localparam int DEF_NUM_SLOTS    = 16;
    localparam int DEF_NUM_RESERVED = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK    = 3'd0,
        REQ_RESTART = 3'd1,
        REQ_QUERY   = 3'd2,
        REQ_ALLOC   = 3'd3,
        REQ_RELEASE = 3'd4
    } req_t;

    typedef struct packed {
        logic            en;
        req_t            req;
        logic [ID_W-1:0] id;
    } slot_cmd_t;

    typedef struct packed {
        logic            used;
        logic            alloc_ok;
        logic [ID_W-1:0] alloc_id;
        logic            rel_ok;
    } slot_stat_t;

endpackage

// ===== rtl/swsp_ram.sv =====
module swsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/swsp_slots.sv =====
module swsp_slots #(
    parameter int NUM_SLOTS    = swsp_pkg::DEF_NUM_SLOTS,
    parameter int NUM_RESERVED = swsp_pkg::DEF_NUM_RESERVED
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  swsp_pkg::slot_cmd_t    cmd,
    output swsp_pkg::slot_stat_t   stat
);

    import swsp_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int SCAN_N = (NUM_SLOTS < ID_SPACE) ? NUM_SLOTS : ID_SPACE;

    logic [NUM_SLOTS-1:0] in_use_reg;
    logic [NUM_SLOTS-1:0] in_use_next;
    logic [NUM_SLOTS-1:0] reserved_mask;
    logic [SLOT_W-1:0]    idx;
    logic                 in_range;
    logic                 is_rsvd;
    logic                 alloc_ok;
    logic [ID_W-1:0]      alloc_id;

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            reserved_mask[i] = (i < NUM_RESERVED);
        end
    end

    assign idx      = SLOT_W'(cmd.id);
    assign in_range = 32'(cmd.id) < 32'(NUM_SLOTS);
    assign is_rsvd  = 32'(cmd.id) < 32'(NUM_RESERVED);

    // lowest free non-reserved slot within the id space
    always_comb
    begin
        alloc_ok = 1'b0;
        alloc_id = '0;
        for (int i = SCAN_N - 1; i >= 0; i--)
        begin
            if (i >= NUM_RESERVED && !in_use_reg[i])
            begin
                alloc_ok = 1'b1;
                alloc_id = ID_W'(i);
            end
        end
    end

    always_comb
    begin
        stat.used     = in_range && in_use_reg[idx];
        stat.alloc_ok = alloc_ok;
        stat.alloc_id = alloc_id;
        stat.rel_ok   = in_range && !is_rsvd;
    end

    always_comb
    begin
        in_use_next = in_use_reg;
        if (cmd.en)
        begin
            case (cmd.req)
                REQ_ALLOC:
                begin
                    if (alloc_ok)
                    begin
                        in_use_next[SLOT_W'(alloc_id)] = 1'b1;
                    end
                end
                REQ_RELEASE:
                begin
                    if (stat.rel_ok)
                    begin
                        in_use_next[idx] = 1'b0;
                    end
                end
                default:
                begin
                    in_use_next = in_use_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= reserved_mask;
        end
        else
        begin
            in_use_reg <= in_use_next;
        end
    end

endmodule

// ===== rtl/stopwatch_slot_pool.sv =====
// Pool of stopwatch slots on a shared 32-bit millisecond counter. One request is taken
// every clock cycle while the output does not stall; its result passes the input register
// and then the result register, and uses the registered read of the start-stamp memory that is
// issued when the request is accepted. Tick advances the counter, restart stamps a used
// slot, query returns counter minus stamp, allocate grants the lowest free non-reserved
// slot below 16, release frees a non-reserved slot. No clearing pass after reset.
module stopwatch_slot_pool #(
    parameter int NUM_SLOTS    = swsp_pkg::DEF_NUM_SLOTS,
    parameter int NUM_RESERVED = swsp_pkg::DEF_NUM_RESERVED
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // timer_id[3:0], zero pad
    input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // alloc_id[3:0], elapsed_ms[35:4], zero pad
    output logic        m_axis_tuser    // ok[0]
);

    import swsp_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);

    logic                 s1_valid_reg;
    req_t                 s1_req_reg;
    logic [ID_W-1:0]      s1_id_reg;
    logic                 out_valid_reg;
    logic                 out_ok_reg;
    logic                 out_ok_next;
    logic [ID_W-1:0]      out_alloc_reg;
    logic [ID_W-1:0]      out_alloc_next;
    logic [MS_W-1:0]      out_elapsed_reg;
    logic [MS_W-1:0]      out_elapsed_next;
    logic [MS_W-1:0]      now_ms_reg;
    logic [MS_W-1:0]      now_ms_next;
    logic [NUM_SLOTS-1:0] stamp_valid_reg;
    logic [NUM_SLOTS-1:0] stamp_valid_next;
    logic                 fwd_reg;
    logic [MS_W-1:0]      fwd_data_reg;

    logic                 advance;
    logic                 proc;
    logic                 accept;
    logic [SLOT_W-1:0]    s1_idx;
    logic [SLOT_W-1:0]    rd_addr;
    logic                 ram_we;
    logic [MS_W-1:0]      ram_q;
    logic [MS_W-1:0]      stamp_rd;
    logic [MS_W-1:0]      stamp_cur;
    slot_cmd_t            cmd;
    slot_stat_t           stat;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign proc          = s1_valid_reg && advance;
    assign s_axis_tready = !s1_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s1_idx        = SLOT_W'(s1_id_reg);
    assign rd_addr       = SLOT_W'(s_axis_tdata[ID_W-1:0]);

    assign cmd.en  = proc;
    assign cmd.req = s1_req_reg;
    assign cmd.id  = s1_id_reg;

    swsp_slots #(
        .NUM_SLOTS    (NUM_SLOTS),
        .NUM_RESERVED (NUM_RESERVED)
    ) u_slots (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign ram_we = proc && (s1_req_reg == REQ_RESTART) && stat.used;

    swsp_ram #(
        .WIDTH (MS_W),
        .DEPTH (NUM_SLOTS)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_idx),
        .wdata (now_ms_reg),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // stamp written on the same edge as the read shows up via the bypass
    assign stamp_rd  = fwd_reg ? fwd_data_reg : ram_q;
    assign stamp_cur = stamp_valid_reg[s1_idx] ? stamp_rd : '0;

    always_comb
    begin
        out_ok_next      = 1'b0;
        out_alloc_next   = '0;
        out_elapsed_next = '0;
        now_ms_next      = now_ms_reg;
        stamp_valid_next = stamp_valid_reg;
        case (s1_req_reg)
            REQ_TICK:
            begin
                out_ok_next = 1'b1;
                now_ms_next = now_ms_reg + 1'b1;
            end
            REQ_RESTART:
            begin
                out_ok_next = stat.used;
                if (stat.used)
                begin
                    stamp_valid_next[s1_idx] = 1'b1;
                end
            end
            REQ_QUERY:
            begin
                out_ok_next = stat.used;
                if (stat.used)
                begin
                    out_elapsed_next = now_ms_reg - stamp_cur;
                end
            end
            REQ_ALLOC:
            begin
                out_ok_next = stat.alloc_ok;
                if (stat.alloc_ok)
                begin
                    out_alloc_next = stat.alloc_id;
                end
            end
            REQ_RELEASE:
            begin
                out_ok_next = stat.rel_ok;
            end
            default:
            begin
                out_ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            now_ms_reg      <= '0;
            stamp_valid_reg <= '0;
            fwd_reg         <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (proc)
            begin
                now_ms_reg      <= now_ms_next;
                stamp_valid_reg <= stamp_valid_next;
            end
            if (accept)
            begin
                fwd_reg <= ram_we && (s1_idx == rd_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg   <= req_t'(s_axis_tuser[REQ_W-1:0]);
            s1_id_reg    <= s_axis_tdata[ID_W-1:0];
            fwd_data_reg <= now_ms_reg;
        end
        if (proc)
        begin
            out_ok_reg      <= out_ok_next;
            out_alloc_reg   <= out_alloc_next;
            out_elapsed_reg <= out_elapsed_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_elapsed_reg, out_alloc_reg};
    assign m_axis_tuser  = out_ok_reg;

endmodule

// ===== test/stopwatch_slot_pool_tb.sv =====
`timescale 1ns / 100ps

module stopwatch_slot_pool_tb;
    import swsp_pkg::*;

    localparam int SLOTS      = DEF_NUM_SLOTS;
    localparam int RESERVED   = DEF_NUM_RESERVED;
    localparam int RAND_ITEMS = 1100;
    localparam int HOLD_LEN   = 300;

    localparam logic [REQ_W-1:0] REQ_UNKNOWN_LO  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_MID = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_HI  = 3'd7;

    typedef struct packed {
        logic            ok;
        logic [ID_W-1:0] alloc_id;
        logic [MS_W-1:0] elapsed_ms;
    } slot_reply_t;

    class slot_reply_board;
        logic [MS_W-1:0] now_ms;
        bit              in_use[SLOTS];
        logic [MS_W-1:0] stamp[SLOTS];
        slot_reply_t     pending_replies[$];
        int              errors;

        function new();
            now_ms = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                in_use[i] = (i < RESERVED);
                stamp[i]  = '0;
            end
            errors = 0;
        endfunction

        function bit slot_used(logic [ID_W-1:0] id);
            if (int'(id) >= SLOTS)
                return 1'b0;
            return in_use[id];
        endfunction

        // advance the pool state and queue the reply for one accepted request
        function void note_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id);
            slot_reply_t r;
            int          top;
            r   = '0;
            top = (SLOTS < ID_SPACE) ? SLOTS : ID_SPACE;
            case (req)
                REQ_TICK:
                begin
                    now_ms = now_ms + 1;
                    r.ok   = 1'b1;
                end
                REQ_RESTART:
                    if (slot_used(id))
                    begin
                        stamp[id] = now_ms;
                        r.ok      = 1'b1;
                    end
                REQ_QUERY:
                    if (slot_used(id))
                    begin
                        r.elapsed_ms = now_ms - stamp[id];
                        r.ok         = 1'b1;
                    end
                REQ_ALLOC:
                    for (int i = RESERVED; i < top; i++)
                        if (!in_use[i])
                        begin
                            in_use[i]  = 1'b1;
                            r.alloc_id = ID_W'(i);
                            r.ok       = 1'b1;
                            break;
                        end
                REQ_RELEASE:
                    if (int'(id) >= RESERVED && int'(id) < SLOTS)
                    begin
                        in_use[id] = 1'b0;
                        r.ok       = 1'b1;
                    end
                default: ;
            endcase
            pending_replies.push_back(r);
        endfunction

        task report(string what, logic [MS_W-1:0] got, logic [MS_W-1:0] want);
            $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
            errors++;
        endtask

        task check_reply(logic ok, logic [ID_W-1:0] alloc_id, logic [MS_W-1:0] elapsed_ms);
            slot_reply_t want;
            if (pending_replies.size() == 0)
            begin
                report("unexpected reply", {alloc_id, elapsed_ms[27:0]}, '0);
                return;
            end
            want = pending_replies.pop_front();
            if (ok !== want.ok)
                report("ok", MS_W'(ok), MS_W'(want.ok));
            if (alloc_id !== want.alloc_id)
                report("alloc_id", MS_W'(alloc_id), MS_W'(want.alloc_id));
            if (elapsed_ms !== want.elapsed_ms)
                report("elapsed_ms", elapsed_ms, want.elapsed_ms);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;

    slot_reply_board board;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;

    stopwatch_slot_pool dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_req)
            begin
                repeat (HOLD_LEN)
                begin
                    m_axis_tready <= 1'b0;
                    @(posedge clk);
                end
                hold_req = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge clk);
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_reply(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[35:4]);

    task send_req(logic [REQ_W-1:0] req, logic [ID_W-1:0] id);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, id};
        s_axis_tuser  <= req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_request(req, id);
    endtask

    // mostly address slots that are in use so restart and query do real work
    function logic [ID_W-1:0] pick_id();
        int used_ids[$];
        for (int i = 0; i < SLOTS; i++)
            if (board.in_use[i])
                used_ids.push_back(i);
        if ($urandom_range(9) < 7 && used_ids.size() > 0)
            return ID_W'(used_ids[$urandom_range(used_ids.size() - 1)]);
        return ID_W'($urandom_range(ID_SPACE - 1));
    endfunction

    task send_random();
        int               pick;
        logic [ID_W-1:0]  id;
        pick = $urandom_range(99);
        if (pick < 2)
        begin
            // exhaust the pool
            repeat (ID_SPACE - RESERVED + 2)
                send_req(REQ_ALLOC, ID_W'($urandom_range(ID_SPACE - 1)));
        end
        else if (pick < 8)
        begin
            // restart, let time pass, read back
            id = pick_id();
            send_req(REQ_RESTART, id);
            repeat ($urandom_range(12))
                send_req(REQ_TICK, ID_W'($urandom_range(ID_SPACE - 1)));
            send_req(REQ_QUERY, id);
        end
        else if (pick < 32)
            send_req(REQ_TICK, ID_W'($urandom_range(ID_SPACE - 1)));
        else if (pick < 46)
            send_req(REQ_RESTART, pick_id());
        else if (pick < 64)
            send_req(REQ_QUERY, pick_id());
        else if (pick < 78)
            send_req(REQ_ALLOC, ID_W'($urandom_range(ID_SPACE - 1)));
        else if (pick < 94)
            send_req(REQ_RELEASE, ID_W'($urandom_range(ID_SPACE - 1)));
        else
            send_req(REQ_W'($urandom_range(REQ_UNKNOWN_HI, REQ_UNKNOWN_LO)),
                     ID_W'($urandom_range(ID_SPACE - 1)));
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending_replies.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        hold_req      = 1'b0;
        send_idle_pct = 20;
        recv_idle_pct = 62;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reserved slots, unused slots, pool exhaustion, unknown codes
        send_req(REQ_TICK, 4'd0);
        send_req(REQ_QUERY, 4'd0);
        send_req(REQ_RESTART, 4'd0);
        send_req(REQ_TICK, 4'd15);
        send_req(REQ_TICK, 4'd0);
        send_req(REQ_QUERY, 4'd0);
        send_req(REQ_QUERY, 4'd15);
        send_req(REQ_RESTART, 4'd15);
        send_req(REQ_RELEASE, 4'd2);
        send_req(REQ_RELEASE, 4'd9);
        repeat (ID_SPACE - RESERVED + 1)
            send_req(REQ_ALLOC, 4'd0);
        send_req(REQ_RELEASE, 4'd15);
        send_req(REQ_QUERY, 4'd4);
        send_req(REQ_UNKNOWN_LO, 4'd15);
        send_req(REQ_UNKNOWN_MID, 4'd10);
        send_req(REQ_UNKNOWN_HI, 4'd5);

        for (int phase = 0; phase < 3; phase++)
        begin
            drain();
            send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 62 : 0;
            recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 20 : 0;
            for (int n = 0; n < RAND_ITEMS / 3; n++)
            begin
                if (phase == 0 && n == RAND_ITEMS / 6)
                    hold_req = 1'b1;
                if (phase == 2 && n == RAND_ITEMS / 6)
                    drain();
                send_random();
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
